// ===== rtl/mbp_pkg.sv =====
`default_nettype none

package mbp_pkg;

    // Size limits of the packed matrix.
    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int MAX_PANEL = 16;

    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths.
    localparam int WORD_W  = 32;
    localparam int DIM_W   = 7;
    localparam int PANEL_W = 5;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 3;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PULL    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_K  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_K = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_N = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_N = 3'd4;

    // Register reset values.
    localparam logic [DIM_W-1:0]   RST_ROWS_K  = 7'd64;
    localparam logic [DIM_W-1:0]   RST_COLS_N  = 7'd64;
    localparam logic [DIM_W-1:0]   RST_BLOCK_K = 7'd16;
    localparam logic [DIM_W-1:0]   RST_BLOCK_N = 7'd32;
    localparam logic [PANEL_W-1:0] RST_PANEL_N = 5'd8;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [WORD_W-1:0] element_value;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] packed_value;
        logic              is_pad;
        logic              is_last;
        logic              done_res;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic pull;
        logic restart;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/mbp_ctrl.sv =====
`default_nettype none

module mbp_ctrl
    import mbp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [CMD_W-1:0] i_command,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_dp_cmd               o_dp_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_take;
    logic   out_take;

    // A held word can be replaced in the same cycle that it is taken.
    assign o_in_ready  = (r_state == ST_IDLE) || i_out_ready;
    assign o_out_valid = (r_state == ST_HOLD);
    assign in_take     = i_in_valid && o_in_ready;
    assign out_take    = o_out_valid && i_out_ready;

    // Decode the accepted word into datapath commands.
    always_comb begin
        o_dp_cmd.load    = in_take && (i_command == CMD_LOAD);
        o_dp_cmd.pull    = in_take && (i_command == CMD_PULL);
        o_dp_cmd.restart = in_take && (i_command == CMD_RESTART);
    end

    // Output holding state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_dp_cmd.pull) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (o_dp_cmd.pull) n_state = ST_HOLD;
                else if (out_take) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mbp_dpath.sv =====
`default_nettype none

module mbp_dpath
    import mbp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_dp_cmd,
    input  wire logic [WORD_W-1:0]    i_element_value,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    output t_out_word                 o_out_word
);

    localparam logic [DIM_W-1:0]   DIM_ONE   = DIM_W'(1);
    localparam logic [DIM_W-1:0]   ROWS_MAX  = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0]   COLS_MAX  = DIM_W'(MAX_COLS);
    localparam logic [PANEL_W-1:0] PANEL_ONE = PANEL_W'(1);
    localparam logic [PANEL_W-1:0] PANEL_MAX = PANEL_W'(MAX_PANEL);

    // Matrix store, undefined until loaded.
    logic [WORD_W-1:0] mem [STORE_DEPTH];

    // Configuration registers.
    logic [DIM_W-1:0]   r_rows_k;
    logic [DIM_W-1:0]   r_cols_n;
    logic [DIM_W-1:0]   r_block_k;
    logic [DIM_W-1:0]   r_block_n;
    logic [PANEL_W-1:0] r_panel_n;
    logic               cfg_hit;

    // Traversal state.
    logic [ADDR_W-1:0]  r_load_index;
    logic [DIM_W-1:0]   r_block_col;
    logic [DIM_W-1:0]   r_slab_row;
    logic [DIM_W-1:0]   r_panel_off;
    logic [DIM_W-1:0]   r_row_in_slab;
    logic [PANEL_W-1:0] r_col_in_panel;
    logic               r_finished;

    // Result registers.
    logic [WORD_W-1:0] r_mem_q;
    logic              r_zero;
    logic              r_pad;
    logic              r_last;
    logic              r_done;

    // Effective dimensions after saturation.
    logic [DIM_W-1:0]   eff_k;
    logic [DIM_W-1:0]   eff_n;
    logic [DIM_W-1:0]   eff_bk;
    logic [DIM_W-1:0]   eff_bn;
    logic [PANEL_W-1:0] eff_pn;

    // Position and step arithmetic.
    logic [DIM_W-1:0]    row;
    logic [DIM_W:0]      col;
    logic [2*DIM_W:0]    addr_full;
    logic [ADDR_W-1:0]   rd_addr;
    logic                pad;
    logic [PANEL_W:0]    cip_inc;
    logic [DIM_W:0]      ris_inc;
    logic [DIM_W:0]      slab_end_row;
    logic [DIM_W:0]      po_inc;
    logic [DIM_W:0]      remain;
    logic [DIM_W+1:0]    po_ahead;
    logic [DIM_W:0]      bcs_inc;
    logic                panel_wrap;
    logic                row_wrap;
    logic                col_wrap;
    logic                slab_wrap;
    logic                block_wrap;

    assign cfg_hit = i_cfg_we && (i_cfg_index <= REG_PANEL_N);

    // Saturate registers into their legal ranges.
    always_comb begin
        eff_k  = (r_rows_k == '0) ? DIM_ONE : (r_rows_k > ROWS_MAX) ? ROWS_MAX : r_rows_k;
        eff_n  = (r_cols_n == '0) ? DIM_ONE : (r_cols_n > COLS_MAX) ? COLS_MAX : r_cols_n;
        eff_bk = (r_block_k == '0) ? DIM_ONE
               : (r_block_k > ROWS_MAX) ? ROWS_MAX : r_block_k;
        eff_bn = (r_block_n == '0) ? DIM_ONE
               : (r_block_n > COLS_MAX) ? COLS_MAX : r_block_n;
        eff_pn = (r_panel_n == '0) ? PANEL_ONE
               : (r_panel_n > PANEL_MAX) ? PANEL_MAX : r_panel_n;
    end

    // Current element position and store address.
    always_comb begin
        row       = r_slab_row + r_row_in_slab;
        col       = (DIM_W+1)'(r_block_col) + (DIM_W+1)'(r_panel_off)
                  + (DIM_W+1)'(r_col_in_panel);
        pad       = (col >= (DIM_W+1)'(eff_n));
        addr_full = (2*DIM_W+1)'(row * eff_n) + (2*DIM_W+1)'(col);
        rd_addr   = addr_full[ADDR_W-1:0];
    end

    // Nested counter steps. The panel sweep of a block ends at the first panel
    // offset that reaches the rounded block width or the remaining columns.
    always_comb begin
        cip_inc      = (PANEL_W+1)'(r_col_in_panel) + (PANEL_W+1)'(1);
        panel_wrap   = (cip_inc >= (PANEL_W+1)'(eff_pn));
        ris_inc      = (DIM_W+1)'(r_row_in_slab) + (DIM_W+1)'(1);
        slab_end_row = (DIM_W+1)'(r_slab_row) + ris_inc;
        row_wrap     = (ris_inc >= (DIM_W+1)'(eff_bk))
                    || (slab_end_row >= (DIM_W+1)'(eff_k));
        po_inc       = (DIM_W+1)'(r_panel_off) + (DIM_W+1)'(eff_pn);
        remain       = (DIM_W+1)'(eff_n) - (DIM_W+1)'(r_block_col);
        po_ahead     = (DIM_W+2)'(po_inc) + (DIM_W+2)'(eff_pn);
        col_wrap     = (po_ahead > (DIM_W+2)'(eff_bn)) || (po_inc >= remain);
        slab_wrap    = (slab_end_row >= (DIM_W+1)'(eff_k));
        bcs_inc      = (DIM_W+1)'(r_block_col) + po_inc;
        block_wrap   = (bcs_inc >= (DIM_W+1)'(eff_n));
    end

    // Store write on load, read on pull.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            mem[r_load_index] <= i_element_value;
        end
        if (i_dp_cmd.pull) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    // Result flags of a pull.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.pull) begin
            r_done <= r_finished;
            r_pad  <= !r_finished && pad;
            r_zero <= r_finished || pad;
            r_last <= !r_finished && panel_wrap && row_wrap && col_wrap
                   && slab_wrap && block_wrap;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_k  <= RST_ROWS_K;
            r_cols_n  <= RST_COLS_N;
            r_block_k <= RST_BLOCK_K;
            r_block_n <= RST_BLOCK_N;
            r_panel_n <= RST_PANEL_N;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROWS_K:  r_rows_k  <= i_cfg_data;
                REG_COLS_N:  r_cols_n  <= i_cfg_data;
                REG_BLOCK_K: r_block_k <= i_cfg_data;
                REG_BLOCK_N: r_block_n <= i_cfg_data;
                REG_PANEL_N: r_panel_n <= i_cfg_data[PANEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Load pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_dp_cmd.restart) begin
            r_load_index <= '0;
        end else if (i_dp_cmd.load) begin
            r_load_index <= r_load_index + ADDR_W'(1);
        end
    end

    // Traversal counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_dp_cmd.restart || cfg_hit) begin
            r_block_col    <= '0;
            r_slab_row     <= '0;
            r_panel_off    <= '0;
            r_row_in_slab  <= '0;
            r_col_in_panel <= '0;
            r_finished     <= 1'b0;
        end else if (i_dp_cmd.pull && !r_finished) begin
            if (!panel_wrap) begin
                r_col_in_panel <= cip_inc[PANEL_W-1:0];
            end else begin
                r_col_in_panel <= '0;
                if (!row_wrap) begin
                    r_row_in_slab <= ris_inc[DIM_W-1:0];
                end else begin
                    r_row_in_slab <= '0;
                    if (!col_wrap) begin
                        r_panel_off <= po_inc[DIM_W-1:0];
                    end else begin
                        r_panel_off <= '0;
                        if (!slab_wrap) begin
                            r_slab_row <= slab_end_row[DIM_W-1:0];
                        end else begin
                            r_slab_row <= '0;
                            if (!block_wrap) begin
                                r_block_col <= bcs_inc[DIM_W-1:0];
                            end else begin
                                r_block_col <= '0;
                                r_finished  <= 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    // Result word.
    always_comb begin
        o_out_word.packed_value = r_zero ? '0 : r_mem_q;
        o_out_word.is_pad       = r_pad;
        o_out_word.is_last      = r_last;
        o_out_word.done_res     = r_done;
    end

endmodule

`default_nettype wire

// ===== rtl/matrix_b_panel_packer.sv =====
`default_nettype none

// Packs a row-major K x N matrix of 32-bit words into the panel order used by a
// GEMM kernel. Load words feed the 4096-word store in row-major order; each pull
// word then returns one packed word, padded with zero where a panel reaches past
// the last column, and a done word once the layout is exhausted. Load, restart
// and unused commands give no result. A pull gives its result in the cycle
// after acceptance, the delay of the registered store read, and a new word is
// accepted in the same cycle that the held result is taken, so pulls stream at
// one word per cycle while the output side keeps up. The store needs no clearing
// after reset. Configuration writes to registers 0 to 4 restart the pull order.
// The user makes them only while no result is pending; the block does not check.
module matrix_b_panel_packer
    import mbp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data
);

    t_dp_cmd dp_cmd;

    // Handshake control.
    mbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in_word.command),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_dp_cmd    (dp_cmd)
    );

    // Store, counters and result registers.
    mbp_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (dp_cmd),
        .i_element_value (i_in_word.element_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_word      (o_out_word)
    );

endmodule

`default_nettype wire
